// ===== hdl/octi_pkg.sv =====
// ----------------------------------------------------------------------------
// octi_pkg
// Shared constants and types for the octant trilinear table interpolator.
// ----------------------------------------------------------------------------
package octi_pkg;

  // Grid size in cells per axis; the table holds one more node per axis.
  localparam int GRID_X = 32;
  localparam int GRID_Y = 32;
  localparam int GRID_Z = 32;

  localparam int NX1 = GRID_X + 1;
  localparam int NY1 = GRID_Y + 1;
  localparam int NZ1 = GRID_Z + 1;
  localparam int NODE_COUNT = NX1 * NY1 * NZ1;

  // Node coordinate widths.
  localparam int XW = $clog2(NX1);
  localparam int YW = $clog2(NY1);
  localparam int ZW = $clog2(NZ1);

  // Nodes are split over eight banks by the parity of each coordinate.
  localparam int BANKS = 8;
  localparam int HX = (GRID_X + 2) / 2;
  localparam int HY = (GRID_Y + 2) / 2;
  localparam int HZ = (GRID_Z + 2) / 2;
  localparam int BANK_DEPTH = HX * HY * HZ;
  localparam int BAW = $clog2(BANK_DEPTH);

  // Fraction width and its cap (just under 16.0 in Q.16).
  localparam int FW = 20;
  localparam logic [FW-1:0] FRAC_CAP = 20'hFFFFF;
  localparam int ONE_Q16 = 65536;

  // Reciprocals for splitting a linear node index (exact for 16-bit indexes).
  localparam longint unsigned RECIP_Z = ((64'd1 << 32) + NZ1 - 1) / NZ1;
  localparam longint unsigned RECIP_Y = ((64'd1 << 32) + NY1 - 1) / NY1;

  // Queue between the front and back parts.
  localparam int QDEPTH = 8;
  localparam int QAW = $clog2(QDEPTH);
  localparam int FRONT_STAGES = 4;

  // Operation codes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic is_load;
    logic wr_ok;
    logic [XW-1:0] cx;
    logic [YW-1:0] cy;
    logic [ZW-1:0] cz;
    logic [FW-1:0] fx;
    logic [FW-1:0] fy;
    logic [FW-1:0] fz;
    logic [2:0] nonneg;
    logic [3:0][31:0] data;
  } front_item_t;

endpackage

// ===== hdl/octant_trilinear_table_interp_core.sv =====
// ----------------------------------------------------------------------------
// octant_trilinear_table_interp_core
// Trilinear interpolation over one octant of a 3-D table of force and
// potential corrections, with node loads through the same command channel.
// ----------------------------------------------------------------------------
// The block takes one command per clock while busy is low: a load writes one
// node, a query returns one interpolated result, shown for exactly one cycle
// while done is high. The rate of one command per cycle is set by the node
// memory, split into eight parity banks so that all eight neighbors of a
// query are read with one read port per bank. The result side never waits, so
// the queue between the classifying front part and the arithmetic back
// part stays nearly empty and busy stays low; busy only rises if that queue
// holds over three items. A load takes effect for every query accepted
// after it. The grid scale register has its own always-ready channel; the user
// must write it only while no command is in flight, unenforced by the block.
module octant_trilinear_table_interp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               op,
  input  logic [15:0]        entry_index,
  input  logic signed [31:0] entry_force_x,
  input  logic signed [31:0] entry_force_y,
  input  logic signed [31:0] entry_force_z,
  input  logic signed [31:0] entry_potential,
  input  logic signed [31:0] disp_x,
  input  logic signed [31:0] disp_y,
  input  logic signed [31:0] disp_z,
  output logic               done,
  output logic signed [31:0] corr_force_x,
  output logic signed [31:0] corr_force_y,
  output logic signed [31:0] corr_force_z,
  output logic signed [31:0] corr_potential,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  logic [31:0]               grid_scale;
  logic                      accept;
  logic                      front_vld;
  octi_pkg::front_item_t     front_item;
  logic                      head_vld;
  octi_pkg::front_item_t     head_item;
  logic [octi_pkg::QAW:0]    q_count;

  // Scale register; the channel is always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_scale <= 32'd65536;
    end else if (cfg_valid && cfg_ready) begin
      grid_scale <= cfg_data;
    end
  end

  // Hold commands off while the queue could not absorb the front pipeline.
  assign busy   = (q_count > (octi_pkg::QAW+1)'(octi_pkg::QDEPTH - 1 - octi_pkg::FRONT_STAGES));
  assign accept = start && !busy;

  octi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (accept),
    .op         (op),
    .entry_index(entry_index),
    .entry_data ({entry_potential, entry_force_z, entry_force_y, entry_force_x}),
    .disp       ({disp_z, disp_y, disp_x}),
    .grid_scale (grid_scale),
    .item_vld   (front_vld),
    .item       (front_item)
  );

  octi_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_vld),
    .push_item(front_item),
    .pop      (1'b1),
    .head_vld (head_vld),
    .head_item(head_item),
    .count    (q_count)
  );

  octi_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_vld        (head_vld),
    .item          (head_item),
    .done          (done),
    .corr_force_x  (corr_force_x),
    .corr_force_y  (corr_force_y),
    .corr_force_z  (corr_force_z),
    .corr_potential(corr_potential)
  );

endmodule

// ===== hdl/octi_front.sv =====
// ----------------------------------------------------------------------------
// octi_front
// Accepts items, splits load indexes into node coordinates and query
// displacements into cell indexes and fractions.
// ----------------------------------------------------------------------------
module octi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_vld,
  input  logic                 op,
  input  logic [15:0]          entry_index,
  input  logic [3:0][31:0]     entry_data,
  input  logic [2:0][31:0]     disp,
  input  logic [31:0]          grid_scale,
  output logic                 item_vld,
  output octi_pkg::front_item_t item
);

  // Split a scaled position into a clamped cell and a capped fraction.
  function automatic logic [31+octi_pkg::FW:0] split_axis(input logic [47:0] pos,
                                                           input logic [31:0] grid);
    logic [31:0] cell_idx;
    logic [47:0] f;
    cell_idx = pos[47:16];
    if (cell_idx >= grid) begin
      cell_idx = grid - 32'd1;
      f = pos - {cell_idx, 16'b0};
    end else begin
      f = {32'b0, pos[15:0]};
    end
    if (f > 48'(octi_pkg::FRAC_CAP)) begin
      f = 48'(octi_pkg::FRAC_CAP);
    end
    return {cell_idx, f[octi_pkg::FW-1:0]};
  endfunction

  // Stage A: input beat with displacement magnitudes.
  logic              a_vld;
  logic              a_load;
  logic [15:0]       a_idx;
  logic [3:0][31:0]  a_data;
  logic [2:0][31:0]  a_mag;
  logic [2:0]        a_nonneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
    a_load <= (op == octi_pkg::OP_LOAD);
    a_idx  <= entry_index;
    a_data <= entry_data;
    for (int k = 0; k < 3; k++) begin
      a_mag[k]    <= disp[k][31] ? (~disp[k] + 32'd1) : disp[k];
      a_nonneg[k] <= ~disp[k][31];
    end
  end

  // Stage B: scale products and the first index quotient.
  logic              b_vld;
  logic              b_load;
  logic [15:0]       b_idx;
  logic [15:0]       b_q;
  logic [3:0][31:0]  b_data;
  logic [2:0][47:0]  b_pos;
  logic [2:0]        b_nonneg;
  logic [47:0]       qz_prod;
  logic [63:0]       pos_prod [3];

  assign qz_prod = 48'(a_idx) * 48'(octi_pkg::RECIP_Z);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pos_prod[k] = 64'(a_mag[k]) * 64'(grid_scale);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_load   <= a_load;
    b_idx    <= a_idx;
    b_q      <= qz_prod[47:32];
    b_data   <= a_data;
    b_nonneg <= a_nonneg;
    for (int k = 0; k < 3; k++) begin
      b_pos[k] <= pos_prod[k][63:16];
    end
  end

  // Stage C: x and z node coordinates, or cells and fractions for a query.
  logic                     c_vld;
  logic                     c_load;
  logic                     c_ok;
  logic [15:0]              c_q;
  logic [octi_pkg::XW-1:0]  c_cx;
  logic [octi_pkg::YW-1:0]  c_cy;
  logic [octi_pkg::ZW-1:0]  c_cz;
  logic [octi_pkg::FW-1:0]  c_fx;
  logic [octi_pkg::FW-1:0]  c_fy;
  logic [octi_pkg::FW-1:0]  c_fz;
  logic [3:0][31:0]         c_data;
  logic [2:0]               c_nonneg;
  logic [47:0]              qy_prod;
  logic [15:0]              k_rem;
  logic [31+octi_pkg::FW:0] sx;
  logic [31+octi_pkg::FW:0] sy;
  logic [31+octi_pkg::FW:0] sz;

  assign qy_prod = 48'(b_q) * 48'(octi_pkg::RECIP_Y);
  assign k_rem   = b_idx - 16'(b_q * 16'(octi_pkg::NZ1));
  assign sx = split_axis(b_pos[0], 32'(octi_pkg::GRID_X));
  assign sy = split_axis(b_pos[1], 32'(octi_pkg::GRID_Y));
  assign sz = split_axis(b_pos[2], 32'(octi_pkg::GRID_Z));

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_load   <= b_load;
    c_ok     <= (32'(b_idx) < 32'(octi_pkg::NODE_COUNT));
    c_q      <= b_q;
    c_data   <= b_data;
    c_nonneg <= b_nonneg;
    c_fx     <= sx[octi_pkg::FW-1:0];
    c_fy     <= sy[octi_pkg::FW-1:0];
    c_fz     <= sz[octi_pkg::FW-1:0];
    c_cy     <= sy[octi_pkg::FW+octi_pkg::YW-1:octi_pkg::FW];
    if (b_load) begin
      c_cx <= qy_prod[32+octi_pkg::XW-1:32];
      c_cz <= k_rem[octi_pkg::ZW-1:0];
    end else begin
      c_cx <= sx[octi_pkg::FW+octi_pkg::XW-1:octi_pkg::FW];
      c_cz <= sz[octi_pkg::FW+octi_pkg::ZW-1:octi_pkg::FW];
    end
  end

  // Stage D: y node coordinate for a load, then the item goes to the queue.
  logic [15:0] j_rem;

  assign j_rem = c_q - 16'(16'(c_cx) * 16'(octi_pkg::NY1));

  always_ff @(posedge clk) begin
    if (rst) begin
      item_vld <= 1'b0;
    end else begin
      item_vld <= c_vld;
    end
    item.is_load <= c_load;
    item.wr_ok   <= c_ok;
    item.cx      <= c_cx;
    item.cy      <= c_load ? j_rem[octi_pkg::YW-1:0] : c_cy;
    item.cz      <= c_cz;
    item.fx      <= c_fx;
    item.fy      <= c_fy;
    item.fz      <= c_fz;
    item.nonneg  <= c_nonneg;
    item.data    <= c_data;
  end

endmodule

// ===== hdl/octi_queue.sv =====
// ----------------------------------------------------------------------------
// octi_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module octi_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  octi_pkg::front_item_t push_item,
  input  logic                  pop,
  output logic                  head_vld,
  output octi_pkg::front_item_t head_item,
  output logic [octi_pkg::QAW:0] count
);

  octi_pkg::front_item_t    store [octi_pkg::QDEPTH];
  logic [octi_pkg::QAW-1:0] wr_ptr;
  logic [octi_pkg::QAW-1:0] rd_ptr;
  logic                     do_pop;

  assign head_vld  = (count != '0);
  assign head_item = store[rd_ptr];
  assign do_pop    = pop && head_vld;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/octi_back.sv =====
// ----------------------------------------------------------------------------
// octi_back
// Banked node memory, trilinear weights, blend and saturation.
// ----------------------------------------------------------------------------
module octi_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_vld,
  input  octi_pkg::front_item_t item,
  output logic                  done,
  output logic signed [31:0]    corr_force_x,
  output logic signed [31:0]    corr_force_y,
  output logic signed [31:0]    corr_force_z,
  output logic signed [31:0]    corr_potential
);

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -52'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // Stage E: bank addresses, write enables and pair weight products.
  logic                      e_vld;
  logic [octi_pkg::BANKS-1:0] e_we;
  logic [octi_pkg::BANKS-1:0][octi_pkg::BAW-1:0] e_addr;
  logic [127:0]              e_data;
  logic signed [43:0]        e_pxy [octi_pkg::BANKS];
  logic signed [21:0]        e_fz [octi_pkg::BANKS];
  logic [2:0]                e_nonneg;

  logic signed [21:0]        facx0, facx1, facy0, facy1, facz0, facz1;
  logic [octi_pkg::XW:0]     xc [octi_pkg::BANKS];
  logic [octi_pkg::YW:0]     yc [octi_pkg::BANKS];
  logic [octi_pkg::ZW:0]     zc [octi_pkg::BANKS];
  logic [31:0]               addr_c [octi_pkg::BANKS];
  logic [2:0]                cor [octi_pkg::BANKS];
  logic [2:0]                load_bank;

  assign facx1 = $signed({2'b0, item.fx});
  assign facy1 = $signed({2'b0, item.fy});
  assign facz1 = $signed({2'b0, item.fz});
  assign facx0 = 22'(octi_pkg::ONE_Q16) - facx1;
  assign facy0 = 22'(octi_pkg::ONE_Q16) - facy1;
  assign facz0 = 22'(octi_pkg::ONE_Q16) - facz1;
  assign load_bank = {item.cx[0], item.cy[0], item.cz[0]};

  // Each bank holds one parity class, so its corner is the cell or the next.
  always_comb begin
    for (int b = 0; b < octi_pkg::BANKS; b++) begin
      cor[b][2] = item.cx[0] ^ b[2];
      cor[b][1] = item.cy[0] ^ b[1];
      cor[b][0] = item.cz[0] ^ b[0];
      xc[b] = {1'b0, item.cx} + (octi_pkg::XW+1)'(cor[b][2]);
      yc[b] = {1'b0, item.cy} + (octi_pkg::YW+1)'(cor[b][1]);
      zc[b] = {1'b0, item.cz} + (octi_pkg::ZW+1)'(cor[b][0]);
      addr_c[b] = (32'(xc[b] >> 1) * 32'(octi_pkg::HY) + 32'(yc[b] >> 1))
                  * 32'(octi_pkg::HZ) + 32'(zc[b] >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
      e_we  <= '0;
    end else begin
      e_vld <= in_vld && !item.is_load;
      for (int b = 0; b < octi_pkg::BANKS; b++) begin
        e_we[b] <= in_vld && item.is_load && item.wr_ok && (load_bank == 3'(b));
      end
    end
    e_data   <= item.data;
    e_nonneg <= item.nonneg;
    for (int b = 0; b < octi_pkg::BANKS; b++) begin
      e_addr[b] <= addr_c[b][octi_pkg::BAW-1:0];
      e_pxy[b]  <= (cor[b][2] ? facx1 : facx0) * (cor[b][1] ? facy1 : facy0);
      e_fz[b]   <= cor[b][0] ? facz1 : facz0;
    end
  end

  // Stage M: node memory access and rounded corner weights.
  logic [127:0]        node_mem [octi_pkg::BANKS][octi_pkg::BANK_DEPTH];
  logic                m_vld;
  logic [127:0]        m_rd [octi_pkg::BANKS];
  logic signed [31:0]  m_w [octi_pkg::BANKS];
  logic [2:0]          m_nonneg;
  logic signed [65:0]  w_full [octi_pkg::BANKS];

  always_comb begin
    for (int b = 0; b < octi_pkg::BANKS; b++) begin
      w_full[b] = (66'(e_pxy[b]) * 66'(e_fz[b]) + 66'sd2147483648) >>> 32;
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < octi_pkg::BANKS; b++) begin
      if (e_we[b]) begin
        node_mem[b][e_addr[b]] <= e_data;
      end
      m_rd[b] <= node_mem[b][e_addr[b]];
      m_w[b]  <= w_full[b][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_vld <= 1'b0;
    end else begin
      m_vld <= e_vld;
    end
    m_nonneg <= e_nonneg;
  end

  // Stage P: node times weight for every bank and field.
  logic                p_vld;
  logic [2:0]          p_nonneg;
  logic signed [63:0]  p_prod [octi_pkg::BANKS][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= m_vld;
    end
    p_nonneg <= m_nonneg;
    for (int b = 0; b < octi_pkg::BANKS; b++) begin
      for (int f = 0; f < 4; f++) begin
        p_prod[b][f] <= $signed(m_rd[b][f*32 +: 32]) * m_w[b];
      end
    end
  end

  // Stages S1 to S3: registered adder tree, then the rounding offset.
  logic                s1_vld, s2_vld, s3_vld;
  logic [2:0]          s1_nonneg, s2_nonneg, s3_nonneg;
  logic signed [64:0]  s1 [4][4];
  logic signed [65:0]  s2 [2][4];
  logic signed [66:0]  s3 [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= p_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
    s1_nonneg <= p_nonneg;
    s2_nonneg <= s1_nonneg;
    s3_nonneg <= s2_nonneg;
    for (int f = 0; f < 4; f++) begin
      for (int n = 0; n < 4; n++) begin
        s1[n][f] <= 65'(p_prod[2*n][f]) + 65'(p_prod[2*n+1][f]);
      end
      for (int n = 0; n < 2; n++) begin
        s2[n][f] <= 66'(s1[2*n][f]) + 66'(s1[2*n+1][f]);
      end
      s3[f] <= 67'(s2[0][f]) + 67'(s2[1][f]) + 67'sd32768;
    end
  end

  // Output beat: scale back to Q16.16, apply the force sign, saturate.
  logic signed [51:0] v [4];

  always_comb begin
    for (int f = 0; f < 4; f++) begin
      v[f] = 52'(s3[f] >>> 16);
      if (f < 3 && s3_nonneg[f]) begin
        v[f] = -v[f];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_vld;
    end
    corr_force_x   <= sat32(v[0]);
    corr_force_y   <= sat32(v[1]);
    corr_force_z   <= sat32(v[2]);
    corr_potential <= sat32(v[3]);
  end

endmodule
